### rtl/sot_pkg.sv
package sot_pkg;

	localparam int TIME_BITS  = 48;
	// 100 times a time value still fits here
	localparam int RATE_W     = TIME_BITS + 7;
	localparam int RATE_LIMIT = 100;
	localparam int CNT_W      = $clog2(TIME_BITS);
	// remainder doubled plus overlap stays below three spans
	localparam int SUM_W      = TIME_BITS + 2;

	typedef logic [TIME_BITS-1:0] time_t;

endpackage

### rtl/segment_overlap_trimmer.sv
// Segment overlap trimmer.
// Input channel (in_valid / in_stall) takes one segment per request: first_of_list,
// wall_start_ms, wall_end_ms and stream_ms. Output channel (out_valid / out_stall)
// gives one result per segment: keep_start_ms, dropped and trimmed, in order.
// A segment that is the first of a list, does not overlap, or lies inside the
// covered wall time goes from S_EVAL straight to S_FIN. A partial overlap
// converts wall overlap to stream time with a restoring multiply-divide that
// consumes one bit of stream_ms per cycle, most significant first, in S_MUL.
// An out-of-range rate is found in S_RATE1 when stream_ms is zero or the rate
// is below 0.01, and in S_RATE2 when the rate is above 100.
// One segment is in work at a time; in_stall is high from acceptance until its
// result is written to the output register, so the next request is taken in the
// cycle after at the earliest.
// The output register may still hold the previous result while the next segment
// is accepted and worked on.
// While out_stall is high and the output register holds a valid result, the
// finished result waits in the last step and the output register holds its value.
// Reset clears the covered wall end, the list history and the output valid.
module segment_overlap_trimmer (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic                    first_of_list,
	input  sot_pkg::time_t          wall_start_ms,
	input  sot_pkg::time_t          wall_end_ms,
	input  sot_pkg::time_t          stream_ms,
	output logic                    out_valid,
	input  logic                    out_stall,
	output sot_pkg::time_t          keep_start_ms,
	output logic                    dropped,
	output logic                    trimmed
);
	import sot_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EVAL,
		S_RATE1,
		S_RATE2,
		S_MUL,
		S_ROUND,
		S_FIN
	} state_t;

	state_t             state_q;
	logic               have_prev_q;
	time_t              fwe_q;

	logic               first_q;
	time_t              ws_q;
	time_t              we_q;
	time_t              sm_q;

	time_t              ov_q;
	time_t              span_q;
	logic               trim_q;
	logic               contain_q;
	time_t              keep_q;

	time_t              rem_q;
	time_t              quo_q;
	time_t              sm_sh_q;
	logic [CNT_W-1:0]   cnt_q;

	logic               out_valid_q;
	time_t              keep_out_q;
	logic               dropped_q;
	logic               trimmed_q;

	logic [SUM_W-1:0]   sum;
	logic [SUM_W-1:0]   span1;
	logic [SUM_W-1:0]   span2;
	logic [SUM_W-1:0]   rem_next;
	logic [1:0]         qdig;
	logic [RATE_W-1:0]  span_x100;
	logic [RATE_W-1:0]  sm_x100;
	logic               out_free;
	logic               is_first;

	// one quotient digit per stream bit: remainder stays below span
	always_comb begin
		sum   = {rem_q, 1'b0} + (sm_sh_q[TIME_BITS-1] ? SUM_W'(ov_q) : '0);
		span1 = SUM_W'(span_q);
		span2 = SUM_W'({span_q, 1'b0});
		if (sum >= span2) begin
			rem_next = sum - span2;
			qdig     = 2'd2;
		end else if (sum >= span1) begin
			rem_next = sum - span1;
			qdig     = 2'd1;
		end else begin
			rem_next = sum;
			qdig     = 2'd0;
		end
	end

	assign span_x100 = RATE_W'(span_q) * RATE_W'(RATE_LIMIT);
	assign sm_x100   = RATE_W'(sm_q) * RATE_W'(RATE_LIMIT);
	assign out_free  = !out_valid_q || !out_stall;
	assign is_first  = first_q || !have_prev_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			have_prev_q <= 1'b0;
			fwe_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_FIN && out_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						first_q <= first_of_list;
						ws_q    <= wall_start_ms;
						we_q    <= wall_end_ms;
						sm_q    <= stream_ms;
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					keep_q <= '0;
					ov_q   <= fwe_q - ws_q;
					span_q <= we_q - ws_q;
					if (is_first) begin
						have_prev_q <= 1'b1;
						fwe_q       <= we_q;
						trim_q      <= 1'b0;
						contain_q   <= 1'b0;
						state_q     <= S_FIN;
					end else begin
						trim_q    <= ws_q < fwe_q;
						contain_q <= (ws_q < fwe_q) && (we_q <= fwe_q);
						if (we_q > fwe_q)
							fwe_q <= we_q;
						// partial overlap needs the rate conversion
						if (ws_q < fwe_q && we_q > fwe_q)
							state_q <= S_RATE1;
						else
							state_q <= S_FIN;
					end
				end
				S_RATE1: begin
					if (sm_q == '0 || span_x100 < RATE_W'(sm_q)) begin
						keep_q  <= ov_q;
						state_q <= S_FIN;
					end else begin
						state_q <= S_RATE2;
					end
				end
				S_RATE2: begin
					if (RATE_W'(span_q) > sm_x100) begin
						keep_q  <= ov_q;
						state_q <= S_FIN;
					end else begin
						rem_q   <= '0;
						quo_q   <= '0;
						sm_sh_q <= sm_q;
						cnt_q   <= CNT_W'(TIME_BITS - 1);
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					rem_q   <= rem_next[TIME_BITS-1:0];
					quo_q   <= {quo_q[TIME_BITS-2:0], 1'b0} + TIME_BITS'(qdig);
					sm_sh_q <= {sm_sh_q[TIME_BITS-2:0], 1'b0};
					cnt_q   <= cnt_q - 1'b1;
					if (cnt_q == '0)
						state_q <= S_ROUND;
				end
				S_ROUND: begin
					// halves round up
					keep_q  <= quo_q +
						TIME_BITS'(SUM_W'({rem_q, 1'b0}) >= span1);
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (out_free) begin
						keep_out_q  <= keep_q;
						trimmed_q   <= trim_q;
						dropped_q   <= contain_q || (trim_q && keep_q >= sm_q);
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall      = state_q != S_IDLE;
	assign out_valid     = out_valid_q;
	assign keep_start_ms = keep_out_q;
	assign dropped       = dropped_q;
	assign trimmed       = trimmed_q;

	a_accept_eval: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> state_q == S_EVAL)
		else $error("accepted request did not start evaluation");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MUL |-> rem_q < span_q)
		else $error("divider remainder not below span");

	a_untrimmed_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !trimmed |-> keep_start_ms == '0 && !dropped)
		else $error("untrimmed result carries a cut or a drop");

	a_history: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> have_prev_q)
		else $error("result given without list history");

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import sot_pkg::*;

	localparam time_t TMAX       = '1;
	localparam int    IDLE_LIMIT = 4000;

	typedef struct {
		logic  first;
		time_t ws;
		time_t we;
		time_t sm;
	} seg_req_t;

	typedef struct {
		time_t keep;
		logic  dropped;
		logic  trimmed;
	} seg_trim_t;

	logic  clk           = 1'b0;
	logic  arst_n        = 1'b0;
	logic  in_valid      = 1'b0;
	logic  in_stall;
	logic  first_of_list = 1'b0;
	time_t wall_start_ms = '0;
	time_t wall_end_ms   = '0;
	time_t stream_ms     = '0;
	logic  out_valid;
	logic  out_stall     = 1'b0;
	time_t keep_start_ms;
	logic  dropped;
	logic  trimmed;

	seg_req_t  pending_segments[$];
	seg_trim_t expected_trims[$];

	// predictor history
	time_t covered_end  = '0;
	logic  have_history = 1'b0;

	// shadow of the covered end, only used to shape the stimulus
	time_t gen_end = '0;

	int errors      = 0;
	int burst_left  = 0;
	int gap_left    = 0;
	int stall_mode  = 0;
	int mode_left   = 0;
	int idle_cycles = 0;
	int cyc         = 0;

	segment_overlap_trimmer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.first_of_list (first_of_list),
		.wall_start_ms (wall_start_ms),
		.wall_end_ms   (wall_end_ms),
		.stream_ms     (stream_ms),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.keep_start_ms (keep_start_ms),
		.dropped       (dropped),
		.trimmed       (trimmed)
	);

	always #1 clk = ~clk;

	function automatic seg_trim_t trim_segment(logic first, time_t ws, time_t we, time_t sm);
		seg_trim_t    r;
		time_t        ov;
		time_t        span;
		logic [63:0]  sm64;
		logic [63:0]  span64;
		logic [127:0] prod;
		logic [127:0] q;
		logic [127:0] rem;
		logic         rate_ok;
		r.keep    = '0;
		r.dropped = 1'b0;
		r.trimmed = 1'b0;
		if (first || !have_history) begin
			have_history = 1'b1;
			covered_end  = we;
		end else begin
			if (ws < covered_end) begin
				r.trimmed = 1'b1;
				if (we <= covered_end) begin
					r.dropped = 1'b1;
				end else begin
					ov     = covered_end - ws;
					span   = we - ws;
					sm64   = 64'(sm);
					span64 = 64'(span);
					// rate span/stream must lie within 0.01 .. 100
					rate_ok = (sm != 0) && (span64 >= (sm64 + 99) / 100)
						&& ((span64 + 99) / 100 <= sm64);
					if (rate_ok) begin
						prod = 128'(ov) * 128'(sm);
						q    = prod / 128'(span);
						rem  = prod % 128'(span);
						if (rem * 2 >= 128'(span))
							q = q + 1;
					end else begin
						q = 128'(ov);
					end
					r.keep = q[TIME_BITS-1:0];
					if (q >= 128'(sm))
						r.dropped = 1'b1;
				end
			end
			if (we > covered_end)
				covered_end = we;
		end
		return r;
	endfunction

	function automatic time_t rand_bits(int nb);
		logic [63:0] v;
		v = {$urandom, $urandom};
		if (nb < 64)
			v = v & ((64'd1 << nb) - 1);
		return v[TIME_BITS-1:0];
	endfunction

	function automatic time_t sat_add(time_t a, time_t b);
		logic [TIME_BITS:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[TIME_BITS] ? TMAX : s[TIME_BITS-1:0];
	endfunction

	task automatic add_seg(logic first, time_t ws, time_t we, time_t sm);
		seg_req_t s;
		s.first = first;
		s.ws    = ws;
		s.we    = we;
		s.sm    = sm;
		pending_segments.push_back(s);
		if (first || we > gen_end)
			gen_end = we;
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin : seg_driver
		seg_req_t nxt;
		if (!arst_n) begin
			in_valid      <= 1'b0;
			first_of_list <= 1'b0;
			wall_start_ms <= '0;
			wall_end_ms   <= '0;
			stream_ms     <= '0;
			burst_left    <= 0;
			gap_left      <= 0;
		end else begin
			if (in_valid && !in_stall)
				expected_trims.push_back(trim_segment(first_of_list, wall_start_ms,
					wall_end_ms, stream_ms));
			if (!in_valid || !in_stall) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (pending_segments.size() != 0) begin
					nxt = pending_segments.pop_front();
					in_valid      <= 1'b1;
					first_of_list <= nxt.first;
					wall_start_ms <= nxt.ws;
					wall_end_ms   <= nxt.we;
					stream_ms     <= nxt.sm;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 24);
						gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 80);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and receiver stall pattern
	always @(posedge clk or negedge arst_n) begin : seg_monitor
		seg_trim_t e;
		if (!arst_n) begin
			out_stall  <= 1'b0;
			stall_mode <= 0;
			mode_left  <= 0;
			cyc        <= 0;
		end else begin
			cyc <= cyc + 1;
			if (out_valid && !out_stall) begin
				if (expected_trims.size() == 0) begin
					$display("%0t: result with no request pending: keep %0d dropped %0b trimmed %0b",
						$time, keep_start_ms, dropped, trimmed);
					errors <= errors + 1;
				end else begin
					e = expected_trims.pop_front();
					if (keep_start_ms !== e.keep || dropped !== e.dropped
						|| trimmed !== e.trimmed) begin
						errors <= errors + 1;
						if (keep_start_ms !== e.keep)
							$display("%0t: keep_start_ms expected %0d actual %0d",
								$time, e.keep, keep_start_ms);
						if (dropped !== e.dropped)
							$display("%0t: dropped expected %0b actual %0b",
								$time, e.dropped, dropped);
						if (trimmed !== e.trimmed)
							$display("%0t: trimmed expected %0b actual %0b",
								$time, e.trimmed, trimmed);
					end
				end
			end
			if (mode_left == 0) begin
				stall_mode <= $urandom_range(0, 3);
				mode_left  <= $urandom_range(20, 400);
			end else begin
				mode_left <= mode_left - 1;
			end
			case (stall_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= 1'($urandom_range(0, 1));
				2: out_stall <= ($urandom_range(0, 9) < 8);
				default: out_stall <= cyc[3];
			endcase
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : stimulus
		int          n_rand;
		int          list_len;
		int          nb;
		int          kind;
		logic        first;
		time_t       ws;
		time_t       we;
		time_t       sm;
		time_t       span;
		time_t       ov;
		logic [63:0] tmp;

		// directed: no history after reset, touching, contained, partial, rounding
		add_seg(1'b0, 48'd100, 48'd200, 48'd100);
		add_seg(1'b0, 48'd200, 48'd300, 48'd100);
		add_seg(1'b0, 48'd250, 48'd300, 48'd50);
		add_seg(1'b0, 48'd250, 48'd350, 48'd100);
		add_seg(1'b0, 48'd349, 48'd353, 48'd2);
		add_seg(1'b0, 48'd352, 48'd354, 48'd1);
		// zero stream, rate just above 100, exactly 100, below 0.01, exactly 0.01
		add_seg(1'b0, 48'd350, 48'd360, 48'd0);
		add_seg(1'b0, 48'd355, 48'd1365, 48'd10);
		add_seg(1'b0, 48'd1360, 48'd2360, 48'd10);
		add_seg(1'b0, 48'd2359, 48'd2361, 48'd201);
		add_seg(1'b0, 48'd2360, 48'd2362, 48'd200);
		// new list while history is set, then full-range times
		add_seg(1'b1, 48'd0, 48'd10, 48'd10);
		add_seg(1'b0, 48'd0, TMAX, TMAX);
		add_seg(1'b0, TMAX - 1, TMAX, TMAX);
		add_seg(1'b1, TMAX, TMAX, TMAX);
		add_seg(1'b1, 48'd0, 48'd1, 48'd0);
		add_seg(1'b0, 48'd0, TMAX, TMAX);
		add_seg(1'b1, TMAX, 48'd0, 48'd0);
		add_seg(1'b0, TMAX, 48'd0, TMAX);
		// trim just below and beyond the stream length
		add_seg(1'b1, 48'd1000, 48'd2000, 48'd1000);
		add_seg(1'b0, 48'd1001, 48'd2001, 48'd1000);
		add_seg(1'b0, 48'd1002, 48'd2002, 48'd1);
		add_seg(1'b1, 48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA, 48'h7FFF_FFFF_FFFF);
		add_seg(1'b0, 48'h8000_0000_0000, TMAX, 48'h5555_5555_5555);

		n_rand = 0;
		while (n_rand < 850) begin
			list_len = $urandom_range(1, 12);
			nb = ($urandom_range(0, 3) == 0) ? $urandom_range(21, 48) : $urandom_range(2, 20);
			for (int k = 0; k < list_len; k++) begin
				kind  = (k == 0) ? -1 : $urandom_range(0, 9);
				first = 1'b0;
				if (kind == -1) begin
					first = ($urandom_range(0, 7) != 0);
					ws = rand_bits(($urandom_range(0, 1) == 0) ? 48 : nb + 2);
					we = sat_add(ws, rand_bits(nb));
				end else if (kind <= 1) begin
					// no overlap
					ws = sat_add(gen_end, rand_bits(nb));
					we = sat_add(ws, rand_bits(nb));
				end else if (kind == 2 || (kind <= 8 && (gen_end == 0 || gen_end == TMAX))) begin
					// inside the covered wall time
					ov = rand_bits(nb);
					ws = (gen_end == 0) ? '0 : ((ov >= gen_end) ? '0 : gen_end - 1 - ov);
					we = gen_end - (rand_bits(nb) % (gen_end - ws + 1));
				end else if (kind <= 8) begin
					// partial overlap
					ov = 1 + rand_bits(nb);
					ws = (ov > gen_end) ? '0 : gen_end - ov;
					we = sat_add(gen_end, 1 + rand_bits(nb));
				end else begin
					first = 1'($urandom_range(0, 1));
					ws    = rand_bits(48);
					we    = rand_bits(48);
				end
				span = (we >= ws) ? we - ws : rand_bits(nb);
				case ($urandom_range(0, 9))
					0: sm = '0;
					1: sm = rand_bits(48);
					2: begin
						tmp = 64'(span) / 100 + $urandom_range(0, 2);
						sm = (tmp == 0) ? '0 : time_t'(tmp - 1);
					end
					3: begin
						tmp = 64'(span) * 100 + $urandom_range(0, 2);
						tmp = (tmp == 0) ? 0 : tmp - 1;
						sm = (tmp > 64'(TMAX)) ? TMAX : time_t'(tmp);
					end
					default: begin
						tmp = 64'(span) * 64'($urandom_range(1, 100)) / 64'($urandom_range(1, 100));
						sm = (tmp > 64'(TMAX)) ? TMAX : time_t'(tmp);
					end
				endcase
				add_seg(first, ws, we, sm);
				n_rand++;
			end
		end

		repeat (7) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (pending_segments.size() != 0 || in_valid)
			@(posedge clk);
		while (expected_trims.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
